/* design/nearest_n_point_retention_top_macros.svh */
// assertion macros for the nearest-point retention block
// used by the checker; needs clk and rst_n in the including scope
`ifndef NEAREST_N_POINT_RETENTION_TOP_MACROS_SVH
`define NEAREST_N_POINT_RETENTION_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define NNPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define NNPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nnpr_pkg.sv */
// shared types, codes and constants of the nearest-point retention block
// no dependencies; imported by the top level, the distance unit and the checker
package nnpr_pkg;

  // item kinds
  localparam int KIND_W = 2;
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_START  = 2'd0;
  localparam kind_t KIND_CAND   = 2'd1;
  localparam kind_t KIND_FINISH = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CULL_RADIUS = 1'd0;
  localparam cfg_idx_t CFG_LOCK_ID     = 1'd1;

  // cull radius and its square
  localparam int CULL_W    = 16;
  localparam int CULL_SQ_W = 2 * CULL_W;
  localparam logic [CULL_W-1:0]    CULL_RESET    = 16'd4096;
  localparam logic [CULL_SQ_W-1:0] CULL_SQ_RESET = 32'd16777216;

  // fixed field widths
  localparam int ID_W         = 32;
  localparam int HP_W         = 32;
  localparam int KEPT_COUNT_W = 6;

  // per-axis distance magnitude saturates at 31 bits
  localparam int AXIS_MAG_MAX_W = 31;

  function automatic int axis_mag_w(input int coord_bits);
    return (coord_bits > AXIS_MAG_MAX_W) ? AXIS_MAG_MAX_W : coord_bits;
  endfunction

endpackage

/* design/nearest_n_point_retention_top.sv */
// Nearest-point retention block: keeps up to MAX_KEPT points nearest to a reference point
// and emits them on a finish beat. A start beat and a kind-3 beat are taken without leaving
// the idle state. A candidate beat occupies the block through accept, three stages of the
// shared distance unit, compare and store update; when it fills the store or replaces the
// farthest point, a rescan follows that streams every kept point from the single read port
// of the point memory through the same distance unit, one per cycle. A finish beat produces
// max(1, kept count) result beats, each read from the point memory, loaded into the result
// register and held until out_ready. in_ready is high only while the block is idle. Depends
// on nnpr_pkg, nnpr_ram and nnpr_dist.
module nearest_n_point_retention_top
  import nnpr_pkg::*;
#(
  parameter int MAX_KEPT   = 32,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  kind_t                        in_kind,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [ID_W-1:0]       in_entity_id,
  input  logic signed [HP_W-1:0]       in_hit_points,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_entry_valid,
  output logic signed [COORD_BITS-1:0] out_entry_x,
  output logic signed [COORD_BITS-1:0] out_entry_y,
  output logic                         out_last,
  output logic [KEPT_COUNT_W-1:0]      out_kept_count,
  output logic                         out_limited,
  output logic                         out_has_lock,
  output logic signed [COORD_BITS-1:0] out_locked_x,
  output logic signed [COORD_BITS-1:0] out_locked_y,
  // configuration
  input  logic                         cfg_we,
  input  cfg_idx_t                     cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int MAG_W  = axis_mag_w(COORD_BITS);
  localparam int DIST_W = 2 * MAG_W + 1;
  localparam int CMP_W  = (DIST_W > CULL_SQ_W) ? DIST_W : CULL_SQ_W;
  localparam int PT_W   = 2 * COORD_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_CAND_DIST = 3'd1;
  localparam logic [2:0] ST_CAND_ACT  = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_EMIT_RD   = 3'd4;
  localparam logic [2:0] ST_EMIT_LD   = 3'd5;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [CULL_W-1:0]           cull_radius_r;
  logic [CULL_SQ_W-1:0]        cull_sq_r;
  logic signed [ID_W-1:0]      lock_id_r;
  logic signed [COORD_BITS-1:0] ref_x_r, ref_y_r;
  logic signed [COORD_BITS-1:0] cand_x_r, cand_y_r;
  logic [CNT_W-1:0]            count_r;
  logic [IDX_W-1:0]            far_idx_r;
  logic [DIST_W-1:0]           far_dist_r;
  logic                        limited_r;
  logic                        lock_seen_r;
  logic signed [COORD_BITS-1:0] lock_x_r, lock_y_r;
  logic                        in_range_r, nearer_r;
  logic [CNT_W-1:0]            scan_rd_idx_r, scan_res_idx_r;
  logic                        rd_pend_r;
  logic [IDX_W-1:0]            emit_idx_r;
  logic                        out_valid_r, out_entry_valid_r, out_last_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;

  logic                        in_beat, cand_beat, full, scan_issue;
  logic                        lock_hit, res_last, emit_last, rescan;
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  logic [PT_W-1:0]             ram_wdata, ram_rdata;
  logic                        dist_in_vld, dist_out_vld;
  logic signed [COORD_BITS-1:0] dist_ax, dist_ay;
  logic [DIST_W-1:0]           dist_val;

  // handshake and decode
  assign in_ready   = (state_r == ST_IDLE);
  assign in_beat    = in_valid && in_ready;
  assign cand_beat  = in_beat && (in_kind == KIND_CAND);
  assign full       = (count_r == CNT_W'(MAX_KEPT));
  assign scan_issue = (state_r == ST_SCAN) && (scan_rd_idx_r < count_r);
  assign res_last   = ((scan_res_idx_r + CNT_W'(1)) == count_r);
  assign emit_last  = (count_r == '0) || ((CNT_W'(emit_idx_r) + CNT_W'(1)) == count_r);
  assign rescan     = in_range_r && (full ? nearer_r
                                          : ((count_r + CNT_W'(1)) == CNT_W'(MAX_KEPT)));
  assign lock_hit   = (lock_id_r != '0) && (in_entity_id == lock_id_r) &&
                      !in_hit_points[HP_W-1] && (in_hit_points != '0);

  // point memory: append at count, replace at the farthest index
  assign ram_we    = (state_r == ST_CAND_ACT) && in_range_r && (!full || nearer_r);
  assign ram_waddr = full ? far_idx_r : count_r[IDX_W-1:0];
  assign ram_wdata = {cand_x_r, cand_y_r};
  assign ram_raddr = (state_r == ST_SCAN) ? scan_rd_idx_r[IDX_W-1:0] : emit_idx_r;

  nnpr_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_KEPT)
  ) u_nnpr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // distance unit operands: new candidate or a kept point being rescanned
  assign dist_in_vld = cand_beat || rd_pend_r;
  assign dist_ax     = rd_pend_r ? $signed(ram_rdata[PT_W-1:COORD_BITS]) : in_pos_x;
  assign dist_ay     = rd_pend_r ? $signed(ram_rdata[COORD_BITS-1:0]) : in_pos_y;

  nnpr_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_nnpr_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_vld (dist_in_vld),
    .pt_x      (dist_ax),
    .pt_y      (dist_ay),
    .ref_x     (ref_x_r),
    .ref_y     (ref_y_r),
    .res_vld   (dist_out_vld),
    .res_dist  (dist_val)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && (in_kind == KIND_CAND)) begin
          state_nxt = ST_CAND_DIST;
        end else if (in_beat && (in_kind == KIND_FINISH)) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_CAND_DIST: begin
        if (dist_out_vld) begin
          state_nxt = ST_CAND_ACT;
        end
      end
      ST_CAND_ACT: begin
        state_nxt = rescan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (dist_out_vld && res_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        state_nxt = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_valid_r && out_ready) begin
          state_nxt = out_last_r ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cull_radius_r  <= CULL_RESET;
      cull_sq_r      <= CULL_SQ_RESET;
      lock_id_r      <= '0;
      ref_x_r        <= '0;
      ref_y_r        <= '0;
      count_r        <= '0;
      far_idx_r      <= '0;
      far_dist_r     <= '0;
      limited_r      <= 1'b0;
      lock_seen_r    <= 1'b0;
      lock_x_r       <= '0;
      lock_y_r       <= '0;
      rd_pend_r      <= 1'b0;
      scan_rd_idx_r  <= '0;
      scan_res_idx_r <= '0;
      emit_idx_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cull_sq_r <= CULL_SQ_W'(cull_radius_r) * CULL_SQ_W'(cull_radius_r);
      rd_pend_r <= scan_issue;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CULL_RADIUS: cull_radius_r <= cfg_data[CULL_W-1:0];
          CFG_LOCK_ID:     lock_id_r     <= $signed(cfg_data[ID_W-1:0]);
          default: ;
        endcase
      end

      // accepted input beat
      if (in_beat) begin
        case (in_kind)
          KIND_START: begin
            ref_x_r     <= in_pos_x;
            ref_y_r     <= in_pos_y;
            count_r     <= '0;
            far_idx_r   <= '0;
            far_dist_r  <= '0;
            limited_r   <= 1'b0;
            lock_seen_r <= 1'b0;
            lock_x_r    <= '0;
            lock_y_r    <= '0;
          end
          KIND_CAND: begin
            if (lock_hit) begin
              lock_seen_r <= 1'b1;
              lock_x_r    <= in_pos_x;
              lock_y_r    <= in_pos_y;
            end
          end
          KIND_FINISH: begin
            emit_idx_r <= '0;
          end
          default: ;
        endcase
      end

      // store update after the cull compare
      if (state_r == ST_CAND_ACT) begin
        scan_rd_idx_r  <= '0;
        scan_res_idx_r <= '0;
        if (in_range_r) begin
          if (!full) begin
            count_r <= count_r + CNT_W'(1);
          end else begin
            limited_r <= 1'b1;
          end
        end
      end

      // rescan: issue reads, track the farthest (lowest index on ties)
      if (scan_issue) begin
        scan_rd_idx_r <= scan_rd_idx_r + CNT_W'(1);
      end
      if ((state_r == ST_SCAN) && dist_out_vld) begin
        scan_res_idx_r <= scan_res_idx_r + CNT_W'(1);
        if ((scan_res_idx_r == '0) || (dist_val > far_dist_r)) begin
          far_dist_r <= dist_val;
          far_idx_r  <= scan_res_idx_r[IDX_W-1:0];
        end
      end

      // result beat
      if (state_r == ST_EMIT_LD) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
        if (!out_last_r) begin
          emit_idx_r <= emit_idx_r + IDX_W'(1);
        end
      end
    end
  end

  // candidate payload and compare flags
  always_ff @(posedge clk) begin
    if (cand_beat) begin
      cand_x_r <= in_pos_x;
      cand_y_r <= in_pos_y;
    end
    if ((state_r == ST_CAND_DIST) && dist_out_vld) begin
      in_range_r <= (CMP_W'(dist_val) <= CMP_W'(cull_sq_r));
      nearer_r   <= (dist_val < far_dist_r);
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT_LD) begin
      out_entry_valid_r <= (count_r != '0);
      out_x_r           <= (count_r != '0) ? $signed(ram_rdata[PT_W-1:COORD_BITS]) : '0;
      out_y_r           <= (count_r != '0) ? $signed(ram_rdata[COORD_BITS-1:0]) : '0;
      out_last_r        <= emit_last;
    end
  end

  // outputs
  assign out_valid       = out_valid_r;
  assign out_entry_valid = out_entry_valid_r;
  assign out_entry_x     = out_x_r;
  assign out_entry_y     = out_y_r;
  assign out_last        = out_last_r;
  assign out_kept_count  = KEPT_COUNT_W'(count_r);
  assign out_limited     = limited_r;
  assign out_has_lock    = lock_seen_r;
  assign out_locked_x    = lock_x_r;
  assign out_locked_y    = lock_y_r;

endmodule

/* design/nnpr_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module nnpr_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/nnpr_dist.sv */
// shared squared-distance unit: three-stage pipeline, one point per cycle
// depends on nnpr_pkg for the axis magnitude width
module nnpr_dist
  import nnpr_pkg::*;
#(
  parameter int COORD_BITS = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start_vld,
  input  logic signed [COORD_BITS-1:0]          pt_x,
  input  logic signed [COORD_BITS-1:0]          pt_y,
  input  logic signed [COORD_BITS-1:0]          ref_x,
  input  logic signed [COORD_BITS-1:0]          ref_y,
  output logic                                  res_vld,
  output logic [2*axis_mag_w(COORD_BITS):0]     res_dist
);

  localparam int MAG_W  = axis_mag_w(COORD_BITS);
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 1;
  localparam logic [COORD_BITS-1:0] MAG_LIMIT = COORD_BITS'({MAG_W{1'b1}});

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS:0]        abs_x, abs_y;
  logic [MAG_W-1:0]           mag_x, mag_y;
  logic [MAG_W-1:0]           mag_x_r, mag_y_r;
  logic [SQ_W-1:0]            sq_x_r, sq_y_r;
  logic [DIST_W-1:0]          dist_r;
  logic [2:0]                 vld_r;

  // axis differences, magnitude, saturation
  always_comb begin
    diff_x = {pt_x[COORD_BITS-1], pt_x} - {ref_x[COORD_BITS-1], ref_x};
    diff_y = {pt_y[COORD_BITS-1], pt_y} - {ref_y[COORD_BITS-1], ref_y};
    abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
    abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
    mag_x  = (abs_x[COORD_BITS-1:0] > MAG_LIMIT) ? {MAG_W{1'b1}}
                                                 : abs_x[MAG_W-1:0];
    mag_y  = (abs_y[COORD_BITS-1:0] > MAG_LIMIT) ? {MAG_W{1'b1}}
                                                 : abs_y[MAG_W-1:0];
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start_vld};
    end
  end

  // magnitude, square, sum stages
  always_ff @(posedge clk) begin
    mag_x_r <= mag_x;
    mag_y_r <= mag_y;
    sq_x_r  <= SQ_W'(mag_x_r) * SQ_W'(mag_x_r);
    sq_y_r  <= SQ_W'(mag_y_r) * SQ_W'(mag_y_r);
    dist_r  <= DIST_W'(sq_x_r) + DIST_W'(sq_y_r);
  end

  assign res_vld  = vld_r[2];
  assign res_dist = dist_r;

endmodule

/* design/nnpr_checker.sv */
// port-level checks of the nearest-point retention block, bound to the top level
// depends on nnpr_pkg and nearest_n_point_retention_top_macros.svh
`include "nearest_n_point_retention_top_macros.svh"

module nnpr_checker
  import nnpr_pkg::*;
#(
  parameter int MAX_KEPT   = 32,
  parameter int COORD_BITS = 20
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input kind_t                        in_kind,
  input logic signed [COORD_BITS-1:0] in_pos_x,
  input logic signed [COORD_BITS-1:0] in_pos_y,
  input logic signed [ID_W-1:0]       in_entity_id,
  input logic signed [HP_W-1:0]       in_hit_points,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_entry_valid,
  input logic signed [COORD_BITS-1:0] out_entry_x,
  input logic signed [COORD_BITS-1:0] out_entry_y,
  input logic                         out_last,
  input logic [KEPT_COUNT_W-1:0]      out_kept_count,
  input logic                         out_limited,
  input logic                         out_has_lock,
  input logic signed [COORD_BITS-1:0] out_locked_x,
  input logic signed [COORD_BITS-1:0] out_locked_y,
  input logic                         cfg_we,
  input cfg_idx_t                     cfg_index,
  input logic [CFG_DATA_W-1:0]        cfg_data
);

  // no new input beat while a result beat is pending
  `NNPR_ASSERT_NOW(a_no_input_during_emit, out_valid, !in_ready, "input ready while a result beat waits")

  // a held result beat keeps its payload
  `NNPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_entry_x) && $stable(out_entry_y) && $stable(out_last), "stalled result beat changed")

  // an empty-store beat is the only beat of its run
  `NNPR_ASSERT_NOW(a_empty_beat, out_valid && !out_entry_valid, out_last && (out_kept_count == 0), "empty result beat not last or count nonzero")

  // a start beat clears the run status
  `NNPR_ASSERT_NEXT(a_start_clears, in_valid && in_ready && (in_kind == KIND_START), (out_kept_count == 0) && !out_limited && !out_has_lock, "start beat did not clear the run")

  // kept count stays within the store
  `NNPR_ASSERT_NOW(a_count_bound, out_valid, out_kept_count <= MAX_KEPT, "kept count above store size")

endmodule

bind nearest_n_point_retention_top nnpr_checker #(
  .MAX_KEPT   (MAX_KEPT),
  .COORD_BITS (COORD_BITS)
) u_nnpr_checker (.*);
